/* rtl/tcq_pkg.sv */
`default_nettype none

package tcq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam logic [11:0] THRESH_RST = 12'd10;

	localparam logic OP_ARRIVE   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [1:0] STS_ACCEPTED   = 2'd0;
	localparam logic [1:0] STS_FULL       = 2'd1;
	localparam logic [1:0] STS_DISPATCHED = 2'd2;
	localparam logic [1:0] STS_EMPTY      = 2'd3;

	typedef struct packed {
		logic [7:0]  tag;
		logic [11:0] pages;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef struct packed {
		logic        op;
		logic [7:0]  job_tag;
		logic [11:0] pages;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_tag;
		logic [11:0] out_pages;
		logic [4:0]  short_waiting;
		logic [4:0]  long_waiting;
	} rsp_t;

endpackage

`default_nettype wire

/* rtl/two_class_job_priority_queue_top.sv */
`default_nettype none

// Two-class print job queue. Jobs with fewer pages than the short threshold
// wait in a short list kept sorted by page count (equal counts in arrival
// order); all others wait in a first-in first-out long list; both share
// CAPACITY places. Raise start with a command while busy is low; every
// command gives exactly one result, shown on result for the single cycle in
// which done is high. The receiver cannot hold results off, so capture them
// on that cycle. Timing: a rejected arrival, a long arrival, a short arrival
// into an empty short list and a dispatch from two empty lists give done in
// the cycle after acceptance and never raise busy. A dispatch raises busy
// for one registered read of a list memory. A short arrival into a
// non-empty short list walks it from its tail, one entry per cycle through the
// read port of the short-list memory, moving each entry with more pages one
// place back and then writing the new job into the gap, and busy stays high
// until the job is written. Both lists are ring buffers in RAM with no reset
// of their contents; only their head and tail pointers and counts reset.
// Write short_threshold through cfg_we/cfg_data while the block is idle.
module two_class_job_priority_queue_top #(
	parameter int CAPACITY = tcq_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire tcq_pkg::cmd_t cmd,
	output logic               done,
	output tcq_pkg::rsp_t      result,
	input  wire logic          cfg_we,
	input  wire logic [11:0]   cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INS   = 3'd1;
	localparam logic [2:0] ST_PLACE = 3'd2;
	localparam logic [2:0] ST_POP_S = 3'd3;
	localparam logic [2:0] ST_POP_L = 3'd4;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
	endfunction

	function automatic logic [4:0] to_w5(input logic [CW-1:0] c);
		logic [CW+4:0] e;
		e = {5'b0, c};
		return e[4:0];
	endfunction

	logic [2:0]    state_q;
	logic [11:0]   thr_q;
	logic [CW-1:0] s_cnt_q, l_cnt_q;
	logic [AW-1:0] s_head_q, s_tail_q, l_head_q, l_tail_q;
	logic [AW-1:0] rp_q, wp_q;
	logic [CW-1:0] rem_q;
	tcq_pkg::job_t job_q;
	tcq_pkg::rsp_t result_q;
	logic          done_q;

	logic                     s_we, l_we;
	logic [AW-1:0]            s_waddr, s_raddr;
	logic [tcq_pkg::JOB_W-1:0] s_wdata, s_rdata, l_rdata;
	tcq_pkg::job_t            s_rd, l_rd, new_job;
	logic                     accept, full, is_short, walk_stop;

	assign accept    = start && (state_q == ST_IDLE);
	assign full      = ({1'b0, s_cnt_q} + {1'b0, l_cnt_q}) >= (CW + 1)'(CAPACITY);
	assign is_short  = cmd.pages < thr_q;
	assign new_job   = '{tag: cmd.job_tag, pages: cmd.pages};
	assign s_rd      = tcq_pkg::job_t'(s_rdata);
	assign l_rd      = tcq_pkg::job_t'(l_rdata);
	// the walk comparator, shared by the write mux and the sequencer: stop the walk behind an entry not larger
	assign walk_stop = s_rd.pages <= job_q.pages;

	// Short-list memory port control
	always_comb begin
		s_we    = 1'b0;
		s_waddr = wp_q;
		s_wdata = job_q;
		s_raddr = s_head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.op == tcq_pkg::OP_ARRIVE && !full && is_short) begin
					if (s_cnt_q == '0) begin
						s_we    = 1'b1;
						s_waddr = s_tail_q;
						s_wdata = new_job;
					end else begin
						s_raddr = ptr_dec(s_tail_q);
					end
				end
			end
			ST_INS: begin
				s_we    = 1'b1;
				s_wdata = walk_stop ? job_q : s_rd;
				// read ahead; the data is dropped if the walk stops here
				s_raddr = ptr_dec(rp_q);
			end
			ST_PLACE: begin
				s_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign l_we = accept && cmd.op == tcq_pkg::OP_ARRIVE && !full && !is_short;

	tcq_ram #(.WIDTH(tcq_pkg::JOB_W), .DEPTH(CAPACITY)) u_short_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	tcq_ram #(.WIDTH(tcq_pkg::JOB_W), .DEPTH(CAPACITY)) u_long_ram (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_tail_q),
		.wdata(new_job),
		.raddr(l_head_q),
		.rdata(l_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			thr_q    <= tcq_pkg::THRESH_RST;
			s_cnt_q  <= '0;
			l_cnt_q  <= '0;
			s_head_q <= '0;
			s_tail_q <= '0;
			l_head_q <= '0;
			l_tail_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.op == tcq_pkg::OP_ARRIVE) begin
							if (full) begin
								done_q <= 1'b1;
							end else if (!is_short) begin
								l_tail_q <= ptr_inc(l_tail_q);
								l_cnt_q  <= l_cnt_q + CW'(1);
								done_q   <= 1'b1;
							end else if (s_cnt_q == '0) begin
								s_tail_q <= ptr_inc(s_tail_q);
								s_cnt_q  <= s_cnt_q + CW'(1);
								done_q   <= 1'b1;
							end else begin
								state_q <= ST_INS;
							end
						end else if (s_cnt_q != '0) begin
							s_head_q <= ptr_inc(s_head_q);
							s_cnt_q  <= s_cnt_q - CW'(1);
							state_q  <= ST_POP_S;
						end else if (l_cnt_q != '0) begin
							l_head_q <= ptr_inc(l_head_q);
							l_cnt_q  <= l_cnt_q - CW'(1);
							state_q  <= ST_POP_L;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_INS: begin
					if (walk_stop) begin
						s_tail_q <= ptr_inc(s_tail_q);
						s_cnt_q  <= s_cnt_q + CW'(1);
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (rem_q == CW'(1)) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					s_tail_q <= ptr_inc(s_tail_q);
					s_cnt_q  <= s_cnt_q + CW'(1);
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_POP_S, ST_POP_L: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk pointers, held item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q <= new_job;
				rp_q  <= ptr_dec(s_tail_q);
				wp_q  <= s_tail_q;
				rem_q <= s_cnt_q;
				result_q.out_tag   <= '0;
				result_q.out_pages <= '0;
				if (cmd.op == tcq_pkg::OP_ARRIVE) begin
					result_q.status <= full ? tcq_pkg::STS_FULL : tcq_pkg::STS_ACCEPTED;
				end else begin
					result_q.status <= tcq_pkg::STS_EMPTY;
				end
				result_q.short_waiting <= to_w5(s_cnt_q);
				result_q.long_waiting  <= to_w5(l_cnt_q);
				if (cmd.op == tcq_pkg::OP_ARRIVE && !full) begin
					if (is_short) begin
						result_q.short_waiting <= to_w5(s_cnt_q + CW'(1));
					end else begin
						result_q.long_waiting <= to_w5(l_cnt_q + CW'(1));
					end
				end
			end
			ST_INS: begin
				// advance the hole one place towards the head
				wp_q  <= rp_q;
				rp_q  <= ptr_dec(rp_q);
				rem_q <= rem_q - CW'(1);
				result_q.status        <= tcq_pkg::STS_ACCEPTED;
				result_q.short_waiting <= to_w5(s_cnt_q + CW'(1));
			end
			ST_PLACE: begin
				result_q.status        <= tcq_pkg::STS_ACCEPTED;
				result_q.short_waiting <= to_w5(s_cnt_q + CW'(1));
			end
			ST_POP_S: begin
				result_q.status        <= tcq_pkg::STS_DISPATCHED;
				result_q.out_tag       <= s_rd.tag;
				result_q.out_pages     <= s_rd.pages;
				result_q.short_waiting <= to_w5(s_cnt_q);
			end
			ST_POP_L: begin
				result_q.status       <= tcq_pkg::STS_DISPATCHED;
				result_q.out_tag      <= l_rd.tag;
				result_q.out_pages    <= l_rd.pages;
				result_q.long_waiting <= to_w5(l_cnt_q);
			end
			default: begin
			end
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// The shared capacity is never exceeded
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, s_cnt_q} + {1'b0, l_cnt_q}) <= (CW + 1)'(CAPACITY))
		else $error("list counts exceed capacity");

	// A result is only shown once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while busy");

	// The walk never runs past the head of the short list
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> rem_q != '0 && s_cnt_q != '0)
		else $error("insertion walk out of range");

	// A dispatch from two empty lists answers at once with the empty status
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == tcq_pkg::OP_DISPATCH && s_cnt_q == '0 && l_cnt_q == '0
		|=> done_q && result_q.status == tcq_pkg::STS_EMPTY && !busy)
		else $error("empty dispatch not reported");

	// A dispatch from the long list only happens when the short list is empty
	a_long_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP_L |-> s_cnt_q == '0)
		else $error("long list served before short list");

endmodule

`default_nettype wire

/* rtl/tcq_ram.sv */
`default_nettype none

module tcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
